[design/trl_pkg.sv]
// ----------------------------------------------------------------------------
// trl_pkg
// Shared types, sizes and helper functions for the run-length labeler.
// ----------------------------------------------------------------------------
package trl_pkg;

    localparam int MAX_LINE   = 4096;
    localparam int PIXEL_BITS = 16;

    localparam int PIXEL_W  = 16;
    localparam int LABEL_W  = 16;
    localparam int REPEAT_W = 13;
    localparam int CFG_W    = 16;
    localparam int COUNT_W  = $clog2(MAX_LINE + 1);
    localparam int CMP_W    = (COUNT_W > LABEL_W) ? COUNT_W : LABEL_W;

    localparam logic [PIXEL_W-1:0] PIXEL_MASK =
        PIXEL_W'((64'd1 << PIXEL_BITS) - 64'd1);

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_LINE);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_LABEL_MAX = 1'b1;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               line_end;
    } trl_in_t;

    typedef struct packed {
        logic [LABEL_W-1:0]  label;
        logic [REPEAT_W-1:0] repeat_res;
        logic                line_done;
        logic                last;
    } trl_out_t;

    typedef struct packed {
        logic [1:0] count;
        trl_out_t   first;
        trl_out_t   second;
    } trl_push_t;

    function automatic logic [LABEL_W-1:0] clip_label(
        input logic [COUNT_W-1:0] n,
        input logic [LABEL_W-1:0] lmax
    );
        logic [CMP_W-1:0] n_ext;
        logic [CMP_W-1:0] m_ext;
        n_ext = CMP_W'(n);
        m_ext = CMP_W'(lmax);
        return (n_ext < m_ext) ? LABEL_W'(n) : lmax;
    endfunction

endpackage

[design/trl_run_counter.sv]
// ----------------------------------------------------------------------------
// trl_run_counter
// Input register, threshold compare and run counter producing up to two
// results per pixel.
// ----------------------------------------------------------------------------
module trl_run_counter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         pix_valid,
    output logic                         pix_stall,
    input  trl_pkg::trl_in_t             pix_data,
    input  logic [trl_pkg::CFG_W-1:0]    threshold,
    input  logic [trl_pkg::LABEL_W-1:0]  label_max,
    input  logic                         room,
    output trl_pkg::trl_push_t           push
);
    import trl_pkg::*;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    trl_in_t              s1_data_reg;
    logic [COUNT_W-1:0]   run_count_reg;
    logic [COUNT_W-1:0]   run_count_next;
    logic [COUNT_W-1:0]   count_inc;
    logic [PIXEL_W-1:0]   pix_masked;
    logic                 is_run;
    logic                 fire;
    logic                 accept;

    assign fire      = s1_valid_reg && room;
    assign pix_stall = s1_valid_reg && !room;
    assign accept    = pix_valid && !pix_stall;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (fire)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_data_reg <= pix_data;
        end
    end

    assign pix_masked = s1_data_reg.pixel & PIXEL_MASK;
    assign is_run     = (pix_masked >= threshold);
    assign count_inc  = COUNT_W'(run_count_reg + 1'b1);

    always_comb
    begin
        push           = '0;
        run_count_next = run_count_reg;
        if (fire)
        begin
            if (is_run)
            begin
                if (s1_data_reg.line_end || (count_inc >= COUNT_LIMIT))
                begin
                    push.count            = 2'd1;
                    push.first.label      = clip_label(count_inc, label_max);
                    push.first.repeat_res = REPEAT_W'(count_inc);
                    push.first.line_done  = s1_data_reg.line_end;
                    push.first.last       = 1'b1;
                    run_count_next        = '0;
                end
                else
                begin
                    run_count_next = count_inc;
                end
            end
            else if (run_count_reg != '0)
            begin
                push.count             = 2'd2;
                push.first.label       = clip_label(run_count_reg, label_max);
                push.first.repeat_res  = REPEAT_W'(run_count_reg);
                push.first.line_done   = 1'b0;
                push.first.last        = 1'b0;
                push.second.label      = '0;
                push.second.repeat_res = REPEAT_W'(1);
                push.second.line_done  = s1_data_reg.line_end;
                push.second.last       = 1'b1;
                run_count_next         = '0;
            end
            else
            begin
                push.count            = 2'd1;
                push.first.label      = '0;
                push.first.repeat_res = REPEAT_W'(1);
                push.first.line_done  = s1_data_reg.line_end;
                push.first.last       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_count_reg <= '0;
        end
        else
        begin
            run_count_reg <= run_count_next;
        end
    end

    // A run in progress is always shorter than the longest line.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_count_reg < COUNT_LIMIT)
        else $error("run counter reached the line limit");

    // Only one background pixel after a run produces two results.
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        push.count == 2'd2 |-> !push.first.last && push.second.last)
        else $error("two-result push has wrong last flags");

    // Results are produced only for a held pixel that had queue room.
    a_push_fire: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> s1_valid_reg && room)
        else $error("results pushed without a held pixel");

endmodule

[design/trl_result_queue.sv]
// ----------------------------------------------------------------------------
// trl_result_queue
// Small result queue that takes up to two results per cycle and sends one.
// ----------------------------------------------------------------------------
module trl_result_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  trl_pkg::trl_push_t   push,
    output logic                 room,
    output logic                 res_valid,
    input  logic                 res_stall,
    output trl_pkg::trl_out_t    res_data
);
    import trl_pkg::*;

    trl_out_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg;
    logic [QPTR_W-1:0]     wr_ptr_next;
    logic [QPTR_W-1:0]     rd_ptr_reg;
    logic [QPTR_W-1:0]     rd_ptr_next;
    logic [QCNT_W-1:0]     count_reg;
    logic [QCNT_W-1:0]     count_next;
    logic [QPTR_W-1:0]     wr_ptr_second;
    logic                  pop;

    assign room          = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign res_valid     = (count_reg != '0);
    assign res_data      = entry_reg[rd_ptr_reg];
    assign pop           = res_valid && !res_stall;
    assign wr_ptr_second = QPTR_W'(wr_ptr_reg + 1'b1);

    always_comb
    begin
        wr_ptr_next = QPTR_W'(wr_ptr_reg + push.count);
        rd_ptr_next = pop ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = QCNT_W'(count_reg + QCNT_W'(push.count) - QCNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_second] <= push.second;
        end
    end

    // The queue never holds more results than it has entries.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue overflow");

    // The fill count tracks the pointer distance.
    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(wr_ptr_reg - rd_ptr_reg) == QPTR_W'(count_reg))
        else $error("result queue pointers disagree with count");

endmodule

[design/threshold_run_length_labeler_core.sv]
// ----------------------------------------------------------------------------
// threshold_run_length_labeler_core
// Thresholds the pixels of an image line and emits run-length labels.
// ----------------------------------------------------------------------------
// A pixel request is taken in every cycle while the result side keeps up.
// Each pixel passes an input register, the threshold compare and run
// counter, and a four-entry result queue. Its results are written into the
// queue from the input register, and the queue offers its oldest entry. A
// pixel makes zero, one or two results and the queue sends one result per
// cycle while the output is not stalled, so a background pixel that closes a
// run sends two results; the queue's single output port sets the
// sustained rate. Registers are to be written only while no pixel is in
// flight.
// ----------------------------------------------------------------------------
module threshold_run_length_labeler_core (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       pix_valid,
    output logic                       pix_stall,
    input  trl_pkg::trl_in_t           pix_data,
    output logic                       res_valid,
    input  logic                       res_stall,
    output trl_pkg::trl_out_t          res_data,
    input  logic                       wr_en,
    input  logic                       wr_index,
    input  logic [trl_pkg::CFG_W-1:0]  wr_data
);
    import trl_pkg::*;

    logic [CFG_W-1:0]   threshold_reg;
    logic [LABEL_W-1:0] label_max_reg;
    trl_push_t          push;
    logic               room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= CFG_W'(128);
            label_max_reg <= LABEL_W'(255);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_THRESHOLD: threshold_reg <= wr_data;
                CFG_LABEL_MAX: label_max_reg <= LABEL_W'(wr_data);
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    trl_run_counter u_run_counter (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .threshold (threshold_reg),
        .label_max (label_max_reg),
        .room      (room),
        .push      (push)
    );

    trl_result_queue u_result_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

endmodule

[dv/trl_label_checker.sv]
// ----------------------------------------------------------------------------
// trl_label_checker
// Predicts and checks the run-length labels of the labeler core.
// ----------------------------------------------------------------------------
// This module watches the pixel, result and register-write ports. It keeps
// its own copy of the threshold, the label limit and the run counter. For
// each accepted pixel request it queues the labels that the pixel should
// produce. Each accepted result is compared field by field with the oldest
// queued label. The mismatch count and the number of labels still
// outstanding are handed to the testbench top.
// ----------------------------------------------------------------------------
module trl_label_checker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pix_valid,
    input  logic                      pix_stall,
    input  trl_pkg::trl_in_t          pix_data,
    input  logic                      res_valid,
    input  logic                      res_stall,
    input  trl_pkg::trl_out_t         res_data,
    input  logic                      wr_en,
    input  logic                      wr_index,
    input  logic [trl_pkg::CFG_W-1:0] wr_data,
    output int                        fail_count,
    output int                        pending
);
    import trl_pkg::*;

    localparam logic [CFG_W-1:0] THRESHOLD_RESET = 16'd128;
    localparam logic [CFG_W-1:0] LABEL_MAX_RESET = 16'd255;

    trl_out_t            label_queue[$];
    logic [REPEAT_W-1:0] run_len;
    logic [CFG_W-1:0]    thr_reg;
    logic [CFG_W-1:0]    lmax_reg;
    int                  mismatches = 0;
    int                  results_seen = 0;

    function automatic logic [LABEL_W-1:0] run_label(input logic [REPEAT_W-1:0] n);
        return (LABEL_W'(n) < lmax_reg) ? LABEL_W'(n) : lmax_reg;
    endfunction

    function automatic trl_out_t make_label(
        input logic [LABEL_W-1:0]  lbl,
        input logic [REPEAT_W-1:0] rep,
        input logic                done,
        input logic                fin
    );
        trl_out_t r;
        r.label      = lbl;
        r.repeat_res = rep;
        r.line_done  = done;
        r.last       = fin;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch at result %0d: %s", $realtime, results_seen, what);
    endtask

    task automatic predict_labels(input trl_in_t px);
        logic [PIXEL_W-1:0] value;
        value = px.pixel & PIXEL_MASK;
        if (value >= thr_reg) begin
            run_len = run_len + 1'b1;
            if (px.line_end || run_len >= REPEAT_W'(MAX_LINE)) begin
                label_queue.push_back(make_label(run_label(run_len), run_len,
                                                 px.line_end, 1'b1));
                run_len = '0;
            end
        end
        else begin
            if (run_len != '0) begin
                label_queue.push_back(make_label(run_label(run_len), run_len, 1'b0, 1'b0));
                run_len = '0;
            end
            label_queue.push_back(make_label('0, REPEAT_W'(1), px.line_end, 1'b1));
        end
    endtask

    task automatic compare_label(input trl_out_t got);
        trl_out_t want;
        results_seen++;
        if (label_queue.size() == 0) begin
            report_mismatch($sformatf("unexpected result label=%0d repeat=%0d done=%0b last=%0b",
                                      got.label, got.repeat_res, got.line_done, got.last));
            return;
        end
        want = label_queue.pop_front();
        if (got.label != want.label)
            report_mismatch($sformatf("label got %0d, expected %0d", got.label, want.label));
        if (got.repeat_res != want.repeat_res)
            report_mismatch($sformatf("repeat_res got %0d, expected %0d",
                                      got.repeat_res, want.repeat_res));
        if (got.line_done != want.line_done)
            report_mismatch($sformatf("line_done got %0b, expected %0b",
                                      got.line_done, want.line_done));
        if (got.last != want.last)
            report_mismatch($sformatf("last got %0b, expected %0b", got.last, want.last));
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            label_queue.delete();
            run_len  = '0;
            thr_reg  = THRESHOLD_RESET;
            lmax_reg = LABEL_MAX_RESET;
            pending    <= 0;
            fail_count <= mismatches;
        end
        else begin
            if (wr_en) begin
                if (wr_index == CFG_THRESHOLD)
                    thr_reg = wr_data;
                else if (wr_index == CFG_LABEL_MAX)
                    lmax_reg = wr_data;
            end
            if (res_valid && !res_stall)
                compare_label(res_data);
            if (pix_valid && !pix_stall)
                predict_labels(pix_data);
            pending    <= label_queue.size();
            fail_count <= mismatches;
        end
    end

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the threshold run-length labeler core.
// ----------------------------------------------------------------------------
// A short directed sequence at the reset settings covers background pixels,
// runs closed by background and by the line end, and the pixel extremes.
// A zero threshold then makes every pixel part of a run. Random lines run
// under several register settings, among them the extremes and a zero label
// limit. Both sides idle in random bursts, except in the last phase. The
// checker module predicts and compares every result; this module drives the
// ports and reports the outcome.
// ----------------------------------------------------------------------------
module testbench;
    import trl_pkg::*;

    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 1000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             pix_valid;
    logic             pix_stall;
    trl_in_t          pix_data;
    logic             res_valid;
    logic             res_stall = 1'b0;
    trl_out_t         res_data;
    logic             wr_en;
    logic             wr_index;
    logic [CFG_W-1:0] wr_data;

    int   fail_count;
    int   pending;
    logic calm = 1'b0;
    int   stall_left = 0;
    int   free_left = 0;
    int   quiet_cycles = 0;
    int   cur_thr = 128;
    int   sent = 0;

    threshold_run_length_labeler_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data)
    );

    trl_label_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_data   (pix_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (calm)
            res_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else if (free_left > 0)
        begin
            res_stall <= 1'b0;
            free_left--;
        end
        else
        begin
            res_stall <= 1'b1;
            stall_left = $urandom_range(5, 0);
            free_left  = $urandom_range(24, 1);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_valid && !pix_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_pixel(input logic [PIXEL_W-1:0] value, input logic eol);
        if (!calm && $urandom_range(4) == 0)
        begin
            pix_valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge clk);
        end
        pix_valid         <= 1'b1;
        pix_data.pixel    <= value;
        pix_data.line_end <= eol;
        do @(posedge clk); while (pix_stall);
        sent++;
    endtask

    task automatic quiesce();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] thr, input logic [CFG_W-1:0] lmax);
        quiesce();
        wr_en    <= 1'b1;
        wr_index <= CFG_THRESHOLD;
        wr_data  <= thr;
        @(posedge clk);
        wr_index <= CFG_LABEL_MAX;
        wr_data  <= lmax;
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        cur_thr = thr;
    endtask

    function automatic logic [PIXEL_W-1:0] pick_pixel(input logic want_run);
        logic run_side;
        run_side = want_run || cur_thr == 0;
        if ($urandom_range(7) == 0)
            return PIXEL_W'($urandom);
        if ($urandom_range(9) == 0)
            return run_side ? PIXEL_W'(cur_thr) : PIXEL_W'(cur_thr - 1);
        if (run_side)
            return PIXEL_W'($urandom_range(65535, cur_thr));
        return PIXEL_W'($urandom_range(cur_thr - 1, 0));
    endfunction

    task automatic send_random_line();
        int   len;
        logic in_run;
        len    = ($urandom_range(9) == 0) ? $urandom_range(300, 25) : $urandom_range(24, 1);
        in_run = $urandom_range(1);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(3) == 0)
                in_run = !in_run;
            send_pixel(pick_pixel(in_run), i == len - 1);
        end
    endtask

    task automatic random_phase(input int items);
        int goal;
        goal = sent + items;
        while (sent < goal)
            send_random_line();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        pix_valid <= 1'b0;
        pix_data  <= '0;
        wr_en     <= 1'b0;
        wr_index  <= CFG_THRESHOLD;
        wr_data   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        send_pixel(16'h0000, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'h0080, 1'b0);
        send_pixel(16'h007F, 1'b0);
        send_pixel(16'h0080, 1'b1);
        send_pixel(16'h0000, 1'b1);
        send_pixel(16'h00C8, 1'b0);
        send_pixel(16'h012C, 1'b0);
        send_pixel(16'h007F, 1'b1);
        send_pixel(16'hFFFF, 1'b1);
        send_pixel(16'h8000, 1'b0);
        send_pixel(16'h7FFF, 1'b0);
        send_pixel(16'h0001, 1'b1);

        // With a zero threshold every pixel extends the run.
        configure(16'h0000, 16'hFFFF);
        random_phase(150);

        configure(16'hFFFF, 16'h0001);
        send_pixel(16'hFFFE, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hFFFF, 1'b0);
        send_pixel(16'hFFFE, 1'b1);
        random_phase(200);

        configure(16'h03E8, 16'h0000);
        random_phase(200);

        configure(16'h5A5A, 16'h0003);
        random_phase(100);
        quiesce();
        random_phase(100);

        configure(CFG_W'($urandom), CFG_W'($urandom_range(40, 1)));
        random_phase(250);

        configure(16'hA5A5, 16'h00FF);
        calm <= 1'b1;
        cur_thr = 16'h0080;
        configure(16'h0080, 16'h00FF);
        random_phase(250);

        quiesce();
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[sim.f]
design/trl_pkg.sv
design/trl_run_counter.sv
design/trl_result_queue.sv
design/threshold_run_length_labeler_core.sv
dv/trl_label_checker.sv
dv/testbench.sv
